// ===== rtl/core/wes_pkg.sv =====
// Shared types, codes and a helper function for the weekly event scheduler table.
package wes_pkg;

    localparam int EVENTS = 64;
    localparam int LIGHTS = 32;

    localparam int LID_W  = 8;
    localparam int DAY_W  = 4;
    localparam int MIN_W  = 11;
    localparam int NDAY_W = 3;
    localparam int OUT_W  = 5;
    localparam int CNT_W  = (EVENTS > 1) ? $clog2(EVENTS) : 1;

    localparam logic [1:0] REQ_ON     = 2'd0;
    localparam logic [1:0] REQ_OFF    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_TICK   = 2'd3;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_COMMAND = 2'd1;
    localparam logic [1:0] KIND_DONE    = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [DAY_W-1:0]  DAY_EVERY   = 4'd7;
    localparam logic [DAY_W-1:0]  DAY_WEEKDAY = 4'd8;
    localparam logic [DAY_W-1:0]  DAY_WEEKEND = 4'd9;
    localparam logic [NDAY_W-1:0] DAY_SUNDAY  = 3'd0;
    localparam logic [NDAY_W-1:0] DAY_MONDAY  = 3'd1;
    localparam logic [NDAY_W-1:0] DAY_FRIDAY  = 3'd5;
    localparam logic [NDAY_W-1:0] DAY_SATURDAY = 3'd6;

    typedef struct packed {
        logic [LID_W-1:0] id;
        logic [DAY_W-1:0] day;
        logic [MIN_W-1:0] minute;
        logic             on;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_slot;

    // True when a stored day code covers the given day of the week.
    function automatic logic day_covers(input logic [DAY_W-1:0] code,
                                        input logic [NDAY_W-1:0] today);
        logic hit;
        hit = 1'b0;
        if (code == DAY_EVERY) begin
            hit = 1'b1;
        end
        if (code == {1'b0, today}) begin
            hit = 1'b1;
        end
        if (code == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY)) begin
            hit = 1'b1;
        end
        if (code == DAY_WEEKDAY && today >= DAY_MONDAY && today <= DAY_FRIDAY) begin
            hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

// ===== rtl/core/wes_cell.sv =====
// One slot of the scheduler ring: holds a valid mark and an entry, shifts toward the head.
module wes_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  wes_pkg::t_slot i_next,
    output wes_pkg::t_slot o_slot
);
    import wes_pkg::*;

    logic   r_valid;
    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_next.entry;
        end
    end

    assign o_slot = '{valid: r_valid, entry: r_entry};

endmodule

// ===== rtl/core/wes_ctrl.sv =====
// Head of the ring: request sequencing, per-slot decision, write-back and result register.
module wes_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_req_type,
    input  logic [wes_pkg::LID_W-1:0] i_light_id,
    input  logic [wes_pkg::DAY_W-1:0] i_event_day,
    input  logic [wes_pkg::MIN_W-1:0] i_event_minute,
    input  logic [wes_pkg::NDAY_W-1:0] i_now_day,
    input  logic [wes_pkg::MIN_W-1:0] i_now_minute,
    input  wes_pkg::t_slot            i_head,
    output wes_pkg::t_slot            o_wb,
    output logic                      o_shift,
    output logic                      o_result_valid,
    output logic [1:0]                o_result_kind,
    output logic [1:0]                o_status_code,
    output logic [wes_pkg::OUT_W-1:0] o_light_out,
    output logic                      o_switch_on,
    output logic                      o_last
);
    import wes_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [1:0]          r_req;
    logic [LID_W-1:0]    r_id;
    logic [DAY_W-1:0]    r_eday;
    logic [MIN_W-1:0]    r_emin;
    logic [NDAY_W-1:0]   r_nday;
    logic [MIN_W-1:0]    r_nmin;
    logic                r_open, n_open;
    logic                r_bounds;
    logic                r_have, n_have;
    logic [OUT_W-1:0]    r_hlight, n_hlight;
    logic                r_hon, n_hon;

    logic                r_ov, n_ov;
    logic [1:0]          r_kind, n_kind;
    logic [1:0]          r_st, n_st;
    logic [OUT_W-1:0]    r_light, n_light;
    logic                r_on, n_on;
    logic                r_last, n_last;

    logic                accept;
    logic                in_bounds;
    logic                rm_match;
    logic                fire;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign in_bounds = {1'b0, i_light_id} < (LID_W + 1)'(LIGHTS);

    assign rm_match = i_head.valid && i_head.entry.id == r_id &&
                      i_head.entry.day == r_eday && i_head.entry.minute == r_emin;
    assign fire     = i_head.valid && i_head.entry.minute == r_nmin &&
                      day_covers(i_head.entry.day, r_nday);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_open   = r_open;
        n_have   = r_have;
        n_hlight = r_hlight;
        n_hon    = r_hon;
        n_ov     = 1'b0;
        n_kind   = KIND_STATUS;
        n_st     = ST_OK;
        n_light  = '0;
        n_on     = 1'b0;
        n_last   = 1'b0;
        o_wb     = i_head;
        o_shift  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                    n_have  = 1'b0;
                    n_open  = (i_req_type == REQ_ON || i_req_type == REQ_OFF) && in_bounds;
                end
            end
            S_SCAN: begin
                o_shift = 1'b1;
                n_cnt   = r_cnt + 1'b1;
                unique case (r_req) inside
                    REQ_ON, REQ_OFF: begin
                        // The first free slot to pass the head takes the new entry.
                        if (r_open && !i_head.valid) begin
                            o_wb.valid        = 1'b1;
                            o_wb.entry.id     = r_id;
                            o_wb.entry.day    = r_eday;
                            o_wb.entry.minute = r_emin;
                            o_wb.entry.on     = (r_req == REQ_ON);
                            n_open            = 1'b0;
                        end
                    end
                    REQ_REMOVE: begin
                        if (rm_match) begin
                            o_wb.valid = 1'b0;
                        end
                    end
                    default: begin
                        // A command is held back one hit so that the final one can carry last.
                        if (fire) begin
                            if (r_have) begin
                                n_ov    = 1'b1;
                                n_kind  = KIND_COMMAND;
                                n_light = r_hlight;
                                n_on    = r_hon;
                            end
                            n_have   = 1'b1;
                            n_hlight = i_head.entry.id[OUT_W-1:0];
                            n_hon    = i_head.entry.on;
                        end
                    end
                endcase
                if (r_cnt == CNT_W'(EVENTS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_ov    = 1'b1;
                n_last  = 1'b1;
                n_state = S_IDLE;
                n_have  = 1'b0;
                unique case (r_req) inside
                    REQ_ON, REQ_OFF: begin
                        n_kind = KIND_STATUS;
                        if (r_bounds) begin
                            n_st = ST_BOUNDS;
                        end else if (r_open) begin
                            n_st = ST_FULL;
                        end
                    end
                    REQ_REMOVE: begin
                        n_kind = KIND_STATUS;
                    end
                    default: begin
                        if (r_have) begin
                            n_kind  = KIND_COMMAND;
                            n_light = r_hlight;
                            n_on    = r_hon;
                        end else begin
                            n_kind = KIND_DONE;
                        end
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_open  <= 1'b0;
            r_have  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_open  <= n_open;
            r_have  <= n_have;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req_type;
            r_id     <= i_light_id;
            r_eday   <= i_event_day;
            r_emin   <= i_event_minute;
            r_nday   <= i_now_day;
            r_nmin   <= i_now_minute;
            r_bounds <= (i_req_type == REQ_ON || i_req_type == REQ_OFF) && !in_bounds;
        end
        r_hlight <= n_hlight;
        r_hon    <= n_hon;
        r_kind   <= n_kind;
        r_st     <= n_st;
        r_light  <= n_light;
        r_on     <= n_on;
        r_last   <= n_last;
    end

    assign o_result_valid = r_ov;
    assign o_result_kind  = r_kind;
    assign o_status_code  = r_st;
    assign o_light_out    = r_light;
    assign o_switch_on    = r_on;
    assign o_last         = r_last;

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("accepted request did not start a scan at slot zero");

    a_done_emits_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_ov && r_last && r_state == S_IDLE))
        else $error("end of scan did not deliver a final result");

    a_last_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_last) |-> (r_state == S_IDLE))
        else $error("final result delivered while still busy");

    a_shift_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shift |-> (r_state == S_SCAN && r_cnt <= CNT_W'(EVENTS - 1)))
        else $error("ring rotated outside a scan");

    a_open_only_schedule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_open) |-> (r_req == REQ_ON || r_req == REQ_OFF))
        else $error("free-slot search open for a request that is not a schedule");

endmodule

// ===== rtl/core/weekly_event_scheduler_table.sv =====
// Top level of the weekly event scheduler table: a ring of slot cells and its head controller.
//
//  channel   | ports                                               | transfer
//  ----------+-----------------------------------------------------+---------------------------
//  request   | start, busy, i_req_type .. i_now_minute             | start high while busy low
//  result    | o_result_valid, o_result_kind .. o_last             | every cycle o_result_valid
//
// Each request rotates the ring of EVENTS slot cells once past the head, one slot per cycle,
// and busy stays high from the transfer through the scan and the end-of-scan state.
// Light commands come out in slot order as the ring turns; the final result of a request
// appears in the cycle busy falls, and the next request may be taken in that same cycle.
// Reset (synchronous, i_rst_n low) marks every slot free.
// Results are shown for one cycle only and cannot be held off by the receiver.
module weekly_event_scheduler_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_req_type,
    input  logic [wes_pkg::LID_W-1:0]  i_light_id,
    input  logic [wes_pkg::DAY_W-1:0]  i_event_day,
    input  logic [wes_pkg::MIN_W-1:0]  i_event_minute,
    input  logic [wes_pkg::NDAY_W-1:0] i_now_day,
    input  logic [wes_pkg::MIN_W-1:0]  i_now_minute,
    output logic                       o_result_valid,
    output logic [1:0]                 o_result_kind,
    output logic [1:0]                 o_status_code,
    output logic [wes_pkg::OUT_W-1:0]  o_light_out,
    output logic                       o_switch_on,
    output logic                       o_last
);
    import wes_pkg::*;

    t_slot w_slot [EVENTS];
    t_slot w_wb;
    logic  w_shift;

    // During a scan slots move one place toward cell zero per cycle; the head's write-back enters the tail.
    for (genvar k = 0; k < EVENTS; k++) begin : g_ring
        if (k == EVENTS - 1) begin : g_tail
            wes_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_wb),
                .o_slot  (w_slot[k])
            );
        end else begin : g_body
            wes_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_next  (w_slot[k+1]),
                .o_slot  (w_slot[k])
            );
        end
    end

    wes_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_light_id     (i_light_id),
        .i_event_day    (i_event_day),
        .i_event_minute (i_event_minute),
        .i_now_day      (i_now_day),
        .i_now_minute   (i_now_minute),
        .i_head         (w_slot[0]),
        .o_wb           (w_wb),
        .o_shift        (w_shift),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_status_code  (o_status_code),
        .o_light_out    (o_light_out),
        .o_switch_on    (o_switch_on),
        .o_last         (o_last)
    );

endmodule

// ===== sim/weekly_event_scheduler_table_tb.sv =====
// Self-checking testbench for the weekly event scheduler table.
`timescale 1ns / 100ps

module weekly_event_scheduler_table_tb;
    import wes_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_REQUESTS = 180;

    typedef struct {
        logic [1:0]       kind;
        logic [1:0]       status;
        logic [OUT_W-1:0] light;
        logic             on;
        logic             last;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_req_type;
    logic [LID_W-1:0]   i_light_id;
    logic [DAY_W-1:0]   i_event_day;
    logic [MIN_W-1:0]   i_event_minute;
    logic [NDAY_W-1:0]  i_now_day;
    logic [MIN_W-1:0]   i_now_minute;
    logic               o_result_valid;
    logic [1:0]         o_result_kind;
    logic [1:0]         o_status_code;
    logic [OUT_W-1:0]   o_light_out;
    logic               o_switch_on;
    logic               o_last;

    // Shadow copy of the event table.
    bit               slot_used  [EVENTS];
    logic [LID_W-1:0] slot_light [EVENTS];
    logic [DAY_W-1:0] slot_day   [EVENTS];
    logic [MIN_W-1:0] slot_min   [EVENTS];
    logic             slot_on    [EVENTS];

    t_reply replies_due[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    bit     back_to_back;

    weekly_event_scheduler_table u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_light_id     (i_light_id),
        .i_event_day    (i_event_day),
        .i_event_minute (i_event_minute),
        .i_now_day      (i_now_day),
        .i_now_minute   (i_now_minute),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_status_code  (o_status_code),
        .o_light_out    (o_light_out),
        .o_switch_on    (o_switch_on),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic bit covers_today(input logic [DAY_W-1:0] code,
                                        input logic [NDAY_W-1:0] today);
        case (code)
            DAY_EVERY:   return 1'b1;
            DAY_WEEKDAY: return today >= DAY_MONDAY && today <= DAY_FRIDAY;
            DAY_WEEKEND: return today == DAY_SUNDAY || today == DAY_SATURDAY;
            default:     return code == {1'b0, today};
        endcase
    endfunction

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < EVENTS; i++) begin
            if (slot_used[i]) n++;
        end
        return n;
    endfunction

    // Updates the shadow table for one accepted request and queues the replies it causes.
    task automatic apply_request(input logic [1:0] req, input logic [LID_W-1:0] id,
                                 input logic [DAY_W-1:0] eday, input logic [MIN_W-1:0] emin,
                                 input logic [NDAY_W-1:0] nday, input logic [MIN_W-1:0] nmin);
        t_reply r;
        int     fired;
        r = '{kind: KIND_STATUS, status: ST_OK, light: '0, on: 1'b0, last: 1'b1};
        fired = 0;
        case (req)
            REQ_ON, REQ_OFF: begin
                if (id >= LIGHTS) begin
                    r.status = ST_BOUNDS;
                end else begin
                    r.status = ST_FULL;
                    for (int i = 0; i < EVENTS; i++) begin
                        if (!slot_used[i] && r.status == ST_FULL) begin
                            slot_used[i]  = 1'b1;
                            slot_light[i] = id;
                            slot_day[i]   = eday;
                            slot_min[i]   = emin;
                            slot_on[i]    = (req == REQ_ON);
                            r.status      = ST_OK;
                        end
                    end
                end
                replies_due.push_back(r);
            end
            REQ_REMOVE: begin
                // Every matching slot is freed, not only the first one.
                for (int i = 0; i < EVENTS; i++) begin
                    if (slot_used[i] && slot_light[i] == id && slot_day[i] == eday &&
                        slot_min[i] == emin) begin
                        slot_used[i] = 1'b0;
                    end
                end
                replies_due.push_back(r);
            end
            default: begin
                for (int i = 0; i < EVENTS; i++) begin
                    if (slot_used[i] && slot_min[i] == nmin &&
                        covers_today(slot_day[i], nday)) begin
                        r = '{kind: KIND_COMMAND, status: ST_OK, light: slot_light[i][OUT_W-1:0],
                              on: slot_on[i], last: 1'b0};
                        replies_due.push_back(r);
                        fired++;
                    end
                end
                if (fired == 0) begin
                    r = '{kind: KIND_DONE, status: ST_OK, light: '0, on: 1'b0, last: 1'b1};
                    replies_due.push_back(r);
                end else begin
                    replies_due[replies_due.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    // Sends one request after a random gap (none in back-to-back mode) and returns at the edge of its transfer.
    task automatic send_request(input logic [1:0] req, input logic [LID_W-1:0] id,
                                input logic [DAY_W-1:0] eday, input logic [MIN_W-1:0] emin,
                                input logic [NDAY_W-1:0] nday, input logic [MIN_W-1:0] nmin);
        int gap;
        gap = back_to_back ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_light_id     <= id;
        i_event_day    <= eday;
        i_event_minute <= emin;
        i_now_day      <= nday;
        i_now_minute   <= nmin;
        do @(posedge i_clk); while (busy);
        apply_request(req, id, eday, emin, nday, nmin);
    endtask

    task automatic wait_for_replies();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    // Removes the key of the lowest used slot until the table is empty.
    task automatic clear_table();
        int first;
        do begin
            first = -1;
            for (int i = EVENTS - 1; i >= 0; i--) begin
                if (slot_used[i]) first = i;
            end
            if (first >= 0) begin
                send_request(REQ_REMOVE, slot_light[first], slot_day[first], slot_min[first],
                             NDAY_W'($urandom_range(0, 7)), MIN_W'($urandom_range(0, 2047)));
            end
        end while (first >= 0);
    endtask

    task automatic test_directed();
        send_request(REQ_ON,  8'd0,   DAY_EVERY,   11'd0,    3'd0, 11'd0);
        send_request(REQ_OFF, 8'd31,  DAY_WEEKDAY, 11'd1439, 3'd0, 11'd0);
        send_request(REQ_ON,  8'd32,  4'd3,        11'd5,    3'd0, 11'd0);
        send_request(REQ_OFF, 8'd255, 4'd15,       11'd2047, 3'd7, 11'd2047);
        send_request(REQ_ON,  8'd17,  DAY_WEEKEND, 11'd2047, 3'd0, 11'd0);
        // A day code above the weekend code is stored but can never fire.
        send_request(REQ_OFF, 8'd3,   4'd15,       11'd1000, 3'd0, 11'd0);
        send_request(REQ_ON,  8'd10,  4'd4,        11'd1000, 3'd0, 11'd0);
        send_request(REQ_ON,  8'd10,  4'd4,        11'd1000, 3'd0, 11'd0);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd7, 11'd0);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd3, 11'd1439);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd0, 11'd2047);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd6, 11'd1000);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd4, 11'd1000);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd2, 11'd1439);
        // On day seven only everyday entries fire.
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd7, 11'd1439);
        send_request(REQ_REMOVE, 8'd10, 4'd4, 11'd999,  3'd0, 11'd0);
        send_request(REQ_REMOVE, 8'd10, 4'd4, 11'd1000, 3'd0, 11'd0);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd4, 11'd1000);
        send_request(REQ_REMOVE, 8'd3, 4'd15, 11'd1000, 3'd0, 11'd0);
        send_request(REQ_OFF, 8'd5,   4'd0,        11'd1,    3'd0, 11'd0);
        send_request(REQ_TICK, 8'd0,  4'd0, 11'd0, 3'd0, 11'd1);
        send_request(REQ_REMOVE, 8'd255, 4'd15, 11'd2047, 3'd7, 11'd2047);
    endtask

    task automatic test_full_table();
        logic [MIN_W-1:0] fire_min;
        clear_table();
        fire_min = MIN_W'($urandom_range(0, 2047));
        while (slots_in_use() < EVENTS) begin
            send_request(2'($urandom_range(0, 1)), LID_W'(LIGHTS - 1), DAY_EVERY, fire_min,
                         NDAY_W'($urandom_range(0, 7)), MIN_W'($urandom_range(0, 2047)));
        end
        send_request(REQ_ON, 8'd4, DAY_WEEKEND, fire_min, 3'd0, 11'd0);
        // The id check comes before the free-slot search.
        send_request(REQ_OFF, LID_W'(LIGHTS), DAY_EVERY, fire_min, 3'd0, 11'd0);
        send_request(REQ_TICK, LID_W'($urandom_range(0, 255)), DAY_W'($urandom_range(0, 15)),
                     MIN_W'($urandom_range(0, 2047)), NDAY_W'($urandom_range(0, 7)), fire_min);
        send_request(REQ_REMOVE, LID_W'(LIGHTS - 1), DAY_EVERY, fire_min, 3'd0, 11'd0);
        send_request(REQ_TICK, 8'd0, 4'd0, 11'd0, NDAY_W'($urandom_range(0, 7)), fire_min);
    endtask

    task automatic test_random_traffic(input int count);
        logic [MIN_W-1:0]  hot_min [6];
        logic [1:0]        req;
        logic [LID_W-1:0]  id;
        logic [DAY_W-1:0]  eday;
        logic [MIN_W-1:0]  emin;
        logic [NDAY_W-1:0] nday;
        logic [MIN_W-1:0]  nmin;
        int                sel;
        int                used_idx[$];
        int                pick;
        for (int i = 0; i < 6; i++) hot_min[i] = MIN_W'($urandom_range(0, 2047));
        for (int n = 0; n < count; n++) begin
            if (n % 45 == 0) back_to_back = ($urandom_range(0, 2) == 0);
            if (n % 60 == 59) wait_for_replies();
            if (slots_in_use() >= 56 && $urandom_range(0, 3) == 0) clear_table();
            sel  = $urandom_range(0, 99);
            id   = ($urandom_range(0, 9) == 0) ? LID_W'($urandom_range(32, 255))
                                               : LID_W'($urandom_range(0, 31));
            eday = ($urandom_range(0, 7) == 0) ? DAY_W'($urandom_range(10, 15))
                                               : DAY_W'($urandom_range(0, 9));
            emin = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom_range(0, 2047))
                                                : hot_min[$urandom_range(0, 5)];
            nday = ($urandom_range(0, 15) == 0) ? 3'd7 : NDAY_W'($urandom_range(0, 6));
            nmin = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom_range(0, 2047))
                                                : hot_min[$urandom_range(0, 5)];
            if (sel < 40) begin
                req = 2'($urandom_range(0, 1));
            end else if (sel < 60) begin
                req = REQ_REMOVE;
                used_idx.delete();
                for (int i = 0; i < EVENTS; i++) begin
                    if (slot_used[i]) used_idx.push_back(i);
                end
                if (used_idx.size() != 0 && $urandom_range(0, 4) != 0) begin
                    pick = used_idx[$urandom_range(0, used_idx.size() - 1)];
                    id   = slot_light[pick];
                    eday = slot_day[pick];
                    emin = slot_min[pick];
                end
            end else if (sel < 95) begin
                req = REQ_TICK;
            end else begin
                req  = 2'($urandom_range(0, 3));
                id   = LID_W'($urandom_range(0, 255));
                eday = DAY_W'($urandom_range(0, 15));
                emin = MIN_W'($urandom_range(0, 2047));
                nday = NDAY_W'($urandom_range(0, 7));
                nmin = MIN_W'($urandom_range(0, 2047));
            end
            send_request(req, id, eday, emin, nday, nmin);
        end
        back_to_back = 1'b0;
    endtask

    // Each result is on the ports for one cycle; check it against the oldest reply due.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_result_valid) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result kind=%0d status=%0d light=%0d on=%0d last=%0d",
                         $time, o_result_kind, o_status_code, o_light_out, o_switch_on, o_last);
                fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (o_result_kind !== want.kind || o_status_code !== want.status ||
                    o_light_out !== want.light || o_switch_on !== want.on ||
                    o_last !== want.last) begin
                    $display("%0t: mismatch expected kind=%0d status=%0d light=%0d on=%0d last=%0d",
                             $time, want.kind, want.status, want.light, want.on, want.last);
                    $display("%0t:           actual kind=%0d status=%0d light=%0d on=%0d last=%0d",
                             $time, o_result_kind, o_status_code, o_light_out, o_switch_on,
                             o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        back_to_back   = 1'b0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= REQ_ON;
        i_light_id     <= '0;
        i_event_day    <= '0;
        i_event_minute <= '0;
        i_now_day      <= '0;
        i_now_minute   <= '0;
        for (int i = 0; i < EVENTS; i++) slot_used[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_for_replies();
        test_full_table();
        wait_for_replies();
        test_random_traffic(RANDOM_REQUESTS);
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && replies_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
